@@ rtl/clat_pkg.sv @@
// Package for the closest approach unit: shared widths, reset values and
// the queue status type. No dependencies.
package clat_pkg;

  localparam int POS_WIDTH  = 24;  // default point coordinate width
  localparam int DIR_WIDTH  = 16;  // direction component width
  localparam int DIST_BITS  = 24;  // distance result width
  localparam int THR_WIDTH  = 16;  // parallel threshold register width
  localparam int FIFO_DEPTH = 4;   // entries between front and back, power of two

  localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd1;
  localparam logic [DIST_BITS-1:0] DIST_MAX  = {DIST_BITS{1'b1}};

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

@@ rtl/closest_approach_two_lines_unit.sv @@
// Top level of the closest approach unit for two 3D lines.
// Depends on clat_pkg, clat_front, clat_fifo and clat_back.
//
// Usage:
//   Input channel s_*: one beat carries both lines (point and direction of
//   each). Output channel m_*: one beat per input beat, in order, with the
//   distance in tdata and the parallel flag in tuser.
//   cfg_we_i/cfg_wdata_i write the parallel threshold (cross length units);
//   write it only while the unit is drained.
// Pipeline: 2 front stages, the queue, 2 multiply/sum stages, 32 square
//   root stages (one root bit each), a classify stage, 24 divider stages
//   (one quotient bit each) and the output register.
// Throughput: one beat per cycle unless the output stalls (pipelined back end).
// Reset: all valid bits and the queue clear; the threshold returns to 1.
// Stall: while an output beat waits with m_tready_i low the back end holds;
//   the front keeps taking beats until the queue fills, then s_tready_o drops.
module closest_approach_two_lines_unit #(
  parameter int POS_WIDTH = clat_pkg::POS_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: point_a_x/y/z, dir_a_x/y/z, point_b_x/y/z, dir_b_x/y/z, zero pad
  input  logic s_tvalid_i,
  output logic s_tready_o,
  input  logic [((6*POS_WIDTH+6*clat_pkg::DIR_WIDTH+7)/8)*8-1:0] s_tdata_i,
  // tdata: distance; tuser: parallel
  output logic m_tvalid_o,
  input  logic m_tready_i,
  output logic [clat_pkg::DIST_BITS-1:0] m_tdata_o,
  output logic [0:0] m_tuser_o,
  input  logic cfg_we_i,
  input  logic [clat_pkg::THR_WIDTH-1:0] cfg_wdata_i
);

  localparam int EW = 3*(2*clat_pkg::DIR_WIDTH+1) + 3*(POS_WIDTH+1);

  logic [clat_pkg::THR_WIDTH-1:0] thr_q;
  logic                   push, pop;
  logic [EW-1:0]          push_data, head_data;
  clat_pkg::fifo_status_t fifo_st;
  logic                   par_flag;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= clat_pkg::THR_RESET;
    else if (cfg_we_i) thr_q <= cfg_wdata_i;
  end

  clat_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i, .s_tready_o, .s_tdata_i,
    .push_o(push), .push_data_o(push_data), .full_i(fifo_st.full)
  );

  clat_fifo #(.WIDTH(EW)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(push_data),
    .pop_i(pop), .data_o(head_data), .status_o(fifo_st)
  );

  clat_back #(.POS_WIDTH(POS_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .data_i(head_data), .empty_i(fifo_st.empty), .pop_o(pop),
    .thr_i(thr_q),
    .m_tvalid_o, .m_tready_i, .m_tdata_o, .m_tuser_o(par_flag)
  );

  assign m_tuser_o = par_flag;

  // a parallel result always carries a zero distance
  a_par_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[0] |-> m_tdata_o == '0)
    else $error("parallel beat with nonzero distance");

  // queue never pushed while full nor popped while empty
  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_st.full)
    else $error("queue overflow");

  a_no_udf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_st.empty)
    else $error("queue underflow");

  // threshold holds unless written
  a_thr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(thr_q))
    else $error("threshold changed without write");

endmodule

@@ rtl/clat_front.sv @@
// Front end: takes input beats, forms the direction products, the cross
// product and the point difference, and pushes the last two into the queue.
// Depends on clat_pkg.
module clat_front #(
  parameter int POS_WIDTH = clat_pkg::POS_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [((6*POS_WIDTH+6*clat_pkg::DIR_WIDTH+7)/8)*8-1:0] s_tdata_i,
  output logic                 push_o,
  output logic [3*(2*clat_pkg::DIR_WIDTH+1)+3*(POS_WIDTH+1)-1:0] push_data_o,
  input  logic                 full_i
);

  localparam int DirW  = clat_pkg::DIR_WIDTH;
  localparam int ProdW = 2*DirW;
  localparam int CW    = ProdW + 1;
  localparam int DW    = POS_WIDTH + 1;
  localparam int OffDa = 3*POS_WIDTH;
  localparam int OffPb = 3*POS_WIDTH + 3*DirW;
  localparam int OffDb = 6*POS_WIDTH + 3*DirW;

  logic signed [POS_WIDTH-1:0] pa [3];
  logic signed [POS_WIDTH-1:0] pb [3];
  logic signed [DirW-1:0]      da [3];
  logic signed [DirW-1:0]      db [3];

  logic signed [ProdW-1:0] prod_d [6];
  logic signed [ProdW-1:0] prod_q [6];
  logic signed [DW-1:0]    diff_d [3];
  logic signed [DW-1:0]    diff_q [3];
  logic signed [DW-1:0]    dsub_q [3];
  logic signed [CW-1:0]    cross_d [3];
  logic signed [CW-1:0]    cross_q [3];
  logic                    v1_q, v2_q;
  logic                    st1_rdy, st2_rdy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa[i] = s_tdata_i[i*POS_WIDTH +: POS_WIDTH];
      da[i] = s_tdata_i[OffDa + i*DirW +: DirW];
      pb[i] = s_tdata_i[OffPb + i*POS_WIDTH +: POS_WIDTH];
      db[i] = s_tdata_i[OffDb + i*DirW +: DirW];
      diff_d[i] = DW'(pa[i]) - DW'(pb[i]);
    end
    prod_d[0] = da[1] * db[2];
    prod_d[1] = da[2] * db[1];
    prod_d[2] = da[2] * db[0];
    prod_d[3] = da[0] * db[2];
    prod_d[4] = da[0] * db[1];
    prod_d[5] = da[1] * db[0];
    for (int i = 0; i < 3; i++) begin
      cross_d[i] = CW'(prod_q[2*i]) - CW'(prod_q[2*i+1]);
    end
  end

  assign st2_rdy    = !v2_q || !full_i;
  assign st1_rdy    = !v1_q || st2_rdy;
  assign s_tready_o = st1_rdy;
  assign push_o     = v2_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (st1_rdy) v1_q <= s_tvalid_i;
      if (st2_rdy) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st1_rdy && s_tvalid_i) begin
      prod_q <= prod_d;
      diff_q <= diff_d;
    end
    if (st2_rdy && v1_q) begin
      cross_q <= cross_d;
      dsub_q  <= diff_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      push_data_o[i*CW +: CW]        = cross_q[i];
      push_data_o[3*CW + i*DW +: DW] = dsub_q[i];
    end
  end

endmodule

@@ rtl/clat_fifo.sv @@
// Short queue between front and back, registers for storage.
// Depends on clat_pkg.
module clat_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [WIDTH-1:0]       data_i,
  input  logic                   pop_i,
  output logic [WIDTH-1:0]       data_o,
  output clat_pkg::fifo_status_t status_o
);

  localparam int Depth = clat_pkg::FIFO_DEPTH;
  localparam int AW    = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign data_o          = mem_q[rd_q];
  assign status_o.full   = (cnt_q == CntW'(Depth));
  assign status_o.empty  = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (pop_i)  rd_q <= rd_q + AW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

@@ rtl/clat_back.sv @@
// Back end: squares and dot products, cross length by a bit-per-stage square
// root, parallel test and a bit-per-stage divider, then the output register.
// Depends on clat_pkg.
module clat_back #(
  parameter int POS_WIDTH = clat_pkg::POS_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3*(2*clat_pkg::DIR_WIDTH+1)+3*(POS_WIDTH+1)-1:0] data_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  input  logic [clat_pkg::THR_WIDTH-1:0] thr_i,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [clat_pkg::DIST_BITS-1:0] m_tdata_o,
  output logic                 m_tuser_o
);

  localparam int CW   = 2*clat_pkg::DIR_WIDTH + 1;
  localparam int LW   = CW - 1;
  localparam int SQW  = 2*LW;
  localparam int DW   = POS_WIDTH + 1;
  localparam int PW   = CW + DW;
  localparam int NW   = PW + 2;
  localparam int QB   = clat_pkg::DIST_BITS;

  logic en;
  logic out_v_q;

  assign en    = !out_v_q || m_tready_i;
  assign pop_o = en && !empty_i;

  // stage 1: squares and dot terms
  logic signed [CW-1:0] c [3];
  logic signed [DW-1:0] d [3];
  logic [CW-1:0]        cabs [3];
  logic [LW-1:0]        cm [3];
  logic [SQW-1:0]       sqp_q [3];
  logic signed [PW-1:0] dp_q [3];
  logic                 v1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c[i]    = data_i[i*CW +: CW];
      d[i]    = data_i[3*CW + i*DW +: DW];
      cabs[i] = c[i][CW-1] ? CW'(-c[i]) : c[i];
      cm[i]   = cabs[i][LW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqp_q[i] <= cm[i] * cm[i];
        dp_q[i]  <= c[i] * d[i];
      end
    end
  end

  // stage 2: sums
  logic [SQW-1:0]       sqs_q;
  logic signed [NW-1:0] nsum_q;
  logic                 v2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqs_q  <= sqp_q[0] + sqp_q[1] + sqp_q[2];
      nsum_q <= NW'(dp_q[0]) + NW'(dp_q[1]) + NW'(dp_q[2]);
    end
  end

  // square root, one result bit per stage
  logic [SQW-1:0] sn_in [LW];
  logic [SQW-1:0] sr_in [LW];
  logic [NW-1:0]  sa_in [LW];
  logic           sv_in [LW];
  logic [SQW-1:0] sn_q  [LW];
  logic [SQW-1:0] sr_q  [LW];
  logic [NW-1:0]  sa_q  [LW];
  logic           sv_q  [LW];

  for (genvar s = 0; s < LW; s++) begin : g_sqrt
    localparam int Sh = 2*(LW-1-s);
    logic [SQW-1:0] bitv, trial;
    if (s == 0) begin : g_first
      assign sn_in[s] = sqs_q;
      assign sr_in[s] = '0;
      assign sa_in[s] = nsum_q[NW-1] ? NW'(-nsum_q) : NW'(nsum_q);
      assign sv_in[s] = v2_q;
    end else begin : g_next
      assign sn_in[s] = sn_q[s-1];
      assign sr_in[s] = sr_q[s-1];
      assign sa_in[s] = sa_q[s-1];
      assign sv_in[s] = sv_q[s-1];
    end
    assign bitv  = SQW'(1) << Sh;
    assign trial = sr_in[s] + bitv;
    always_ff @(posedge clk_i) begin
      if (en) begin
        sa_q[s] <= sa_in[s];
        if (sn_in[s] >= trial) begin
          sn_q[s] <= sn_in[s] - trial;
          sr_q[s] <= (sr_in[s] >> 1) + bitv;
        end else begin
          sn_q[s] <= sn_in[s];
          sr_q[s] <= sr_in[s] >> 1;
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[s] <= 1'b0;
      else if (en) sv_q[s] <= sv_in[s];
    end
  end

  // classify: parallel test, saturation test, divider setup
  logic [LW-1:0] len;
  logic [NW-1:0] nhi;
  logic [LW-1:0] len_q, rem0_q;
  logic [QB-1:0] nlow_q;
  logic          par_q, sat_q, vc_q;

  assign len = sr_q[LW-1][LW-1:0];
  assign nhi = sa_q[LW-1] >> QB;

  always_ff @(posedge clk_i) begin
    if (en) begin
      len_q  <= len;
      par_q  <= (len == '0) || (len < LW'(thr_i));
      sat_q  <= (nhi >= NW'(len));
      rem0_q <= nhi[LW-1:0];
      nlow_q <= sa_q[LW-1][QB-1:0];
    end
  end

  // restoring divider, one quotient bit per stage
  logic [LW-1:0] dr_in [QB];
  logic [QB-1:0] dn_in [QB];
  logic [QB-1:0] dq_in [QB];
  logic [LW-1:0] dl_in [QB];
  logic          dp_in [QB], ds_in [QB], dv_in [QB];
  logic [LW-1:0] dr_q  [QB];
  logic [QB-1:0] dn_q  [QB];
  logic [QB-1:0] dq_q  [QB];
  logic [LW-1:0] dl_q  [QB];
  logic          dp_q2 [QB], ds_q [QB], dv_q [QB];

  for (genvar t = 0; t < QB; t++) begin : g_div
    logic [LW:0] tr;
    logic        ge;
    if (t == 0) begin : g_first
      assign dr_in[t] = rem0_q;
      assign dn_in[t] = nlow_q;
      assign dq_in[t] = '0;
      assign dl_in[t] = len_q;
      assign dp_in[t] = par_q;
      assign ds_in[t] = sat_q;
      assign dv_in[t] = vc_q;
    end else begin : g_next
      assign dr_in[t] = dr_q[t-1];
      assign dn_in[t] = dn_q[t-1];
      assign dq_in[t] = dq_q[t-1];
      assign dl_in[t] = dl_q[t-1];
      assign dp_in[t] = dp_q2[t-1];
      assign ds_in[t] = ds_q[t-1];
      assign dv_in[t] = dv_q[t-1];
    end
    assign tr = {dr_in[t], dn_in[t][QB-1]};
    assign ge = (tr >= {1'b0, dl_in[t]});
    always_ff @(posedge clk_i) begin
      if (en) begin
        dr_q[t]  <= ge ? LW'(tr - {1'b0, dl_in[t]}) : tr[LW-1:0];
        dq_q[t]  <= {dq_in[t][QB-2:0], ge};
        dn_q[t]  <= dn_in[t] << 1;
        dl_q[t]  <= dl_in[t];
        dp_q2[t] <= dp_in[t];
        ds_q[t]  <= ds_in[t];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[t] <= 1'b0;
      else if (en) dv_q[t] <= dv_in[t];
    end
  end

  // valid bits of the fixed stages and output register
  logic [QB-1:0] dist_q;
  logic          par_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      vc_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= !empty_i;
      v2_q    <= v1_q;
      vc_q    <= sv_q[LW-1];
      out_v_q <= dv_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      par_out_q <= dp_q2[QB-1];
      if (dp_q2[QB-1])     dist_q <= '0;
      else if (ds_q[QB-1]) dist_q <= clat_pkg::DIST_MAX;
      else                 dist_q <= dq_q[QB-1];
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = dist_q;
  assign m_tuser_o  = par_out_q;

endmodule
